[sv/acss_pkg.sv]
package acss_pkg;

    // field and state widths
    localparam int DATA_W = 16;
    localparam int CNT_W  = 5;
    localparam int SUM_W  = 21;
    localparam int IDX_W  = 3;
    localparam int SLEW_W = DATA_W + 2;

    // default window storage depth
    localparam int WINDOW_DEPTH_DEF = 16;

    // register reset values
    localparam logic [CNT_W-1:0]         WINDOW_LEN_RST = 5'd1;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST    = 16'sh8000;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST    = 16'sh7FFF;
    localparam logic [DATA_W-1:0]        RISE_STEP_RST  = 16'hFFFF;
    localparam logic [DATA_W-1:0]        FALL_STEP_RST  = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_LEN = 3'd0,
        REG_OUT_MIN    = 3'd1,
        REG_OUT_MAX    = 3'd2,
        REG_RISE_STEP  = 3'd3,
        REG_FALL_STEP  = 3'd4
    } cfg_idx_t;

    // request into the window unit
    typedef struct packed {
        logic                     start;
        logic                     clear;
        logic [CNT_W-1:0]         len;
        logic signed [DATA_W-1:0] sample;
    } win_req_t;

    // response from the window unit
    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } win_rsp_t;

    // request into the divider
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } div_req_t;

    // response from the divider
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] mean;
    } div_rsp_t;

endpackage

[sv/acss_window.sv]
module acss_window #(
    parameter int WINDOW_DEPTH = acss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  acss_pkg::win_req_t req,
    output acss_pkg::win_rsp_t rsp
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    typedef enum logic [1:0] {
        W_IDLE = 2'b01,
        W_SWAP = 2'b10
    } win_state_t;

    win_state_t state_reg, state_next;

    logic [acss_pkg::CNT_W-1:0]         fill_reg, fill_next;
    logic [acss_pkg::CNT_W-1:0]         ptr_reg, ptr_next;
    logic signed [acss_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic                               done_reg, done_next;
    logic signed [acss_pkg::DATA_W-1:0] sample_reg;

    // sample memory, one write and one read port
    logic signed [acss_pkg::DATA_W-1:0] mem [WINDOW_DEPTH];
    logic signed [acss_pkg::DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ADDR_W-1:0]                  wr_addr;
    logic signed [acss_pkg::DATA_W-1:0] wr_data;
    logic                               wr_en;

    logic [acss_pkg::CNT_W-1:0] ptr_inc;

    assign rd_addr = ADDR_W'({{ADDR_W{1'b0}}, ptr_reg});
    assign ptr_inc = ptr_reg + 1'b1;

    // memory access
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // incoming sample is held while the oldest entry is read
    always_ff @(posedge clk)
    begin
        if (req.start && state_reg == W_IDLE)
        begin
            sample_reg <= req.sample;
        end
    end

    // fill, replace and running sum update
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        sum_next   = sum_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = ADDR_W'({{ADDR_W{1'b0}}, fill_reg});
        wr_data    = req.sample;
        if (req.clear)
        begin
            state_next = W_IDLE;
            fill_next  = '0;
            ptr_next   = '0;
            sum_next   = '0;
        end
        else
        begin
            unique case (state_reg)
                W_IDLE:
                begin
                    if (req.start)
                    begin
                        if (fill_reg < req.len)
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                            sum_next  = sum_reg + acss_pkg::SUM_W'(req.sample);
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = W_SWAP;
                        end
                    end
                end
                W_SWAP:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_addr;
                    wr_data    = sample_reg;
                    sum_next   = sum_reg - acss_pkg::SUM_W'(rd_data_reg)
                                 + acss_pkg::SUM_W'(sample_reg);
                    ptr_next   = (ptr_inc >= req.len) ? '0 : ptr_inc;
                    done_next  = 1'b1;
                    state_next = W_IDLE;
                end
                default:
                begin
                    state_next = W_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.sum   = sum_reg;
    assign rsp.count = fill_reg;

endmodule

[sv/acss_div.sv]
module acss_div (
    input  logic               clk,
    input  logic               rst_n,
    input  acss_pkg::div_req_t req,
    output acss_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(acss_pkg::SUM_W + 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            cnt_reg, cnt_next;
    logic                         neg_reg, neg_next;
    logic [acss_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [acss_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [acss_pkg::CNT_W-1:0]   div_reg, div_next;

    logic [acss_pkg::CNT_W:0]     trial;
    logic                         ge;
    logic [acss_pkg::DATA_W-1:0]  q_low;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[acss_pkg::SUM_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(acss_pkg::SUM_W);
            neg_next  = req.dividend[acss_pkg::SUM_W-1];
            quo_next  = req.dividend[acss_pkg::SUM_W-1] ? acss_pkg::SUM_W'(-req.dividend)
                                                         : acss_pkg::SUM_W'(req.dividend);
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? acss_pkg::CNT_W'(trial - {1'b0, div_reg})
                          : acss_pkg::CNT_W'(trial);
            quo_next = {quo_reg[acss_pkg::SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // mean fits 16 bits, sign restored after the magnitude divide
    assign q_low    = quo_reg[acss_pkg::DATA_W-1:0];
    assign rsp.done = done_reg;
    assign rsp.mean = neg_reg ? $signed(-q_low) : $signed(q_low);

endmodule

[sv/accel_command_smooth_slew_clamp_unit.sv]
// Acceleration command shaper: each request carries one raw Q8.8 sample, which
// joins a window of the last window_len samples (1 to 16, saturated to
// WINDOW_DEPTH); the truncated mean of the held samples is slew limited by
// rise_step and fall_step against the previous result, clamped to out_min and
// out_max (out_min wins if they cross): exactly one result per request.
// A request passes in order through the window update, the bit-serial divide of
// the running sum by the held count, the slew register and the clamp into the
// output register; once the window is full, the window update also reads the
// oldest sample from the window memory before replacing it. One request is in
// flight at a time, and the next is taken while the result waits.
// Writing window_len empties the window but keeps the previous result; the
// window memory needs no clearing pass after reset. Configuration is taken every
// cycle and must only be written while the unit is idle.
module accel_command_smooth_slew_clamp_unit #(
    parameter int WINDOW_DEPTH = acss_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [acss_pkg::DATA_W-1:0] raw_accel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [acss_pkg::DATA_W-1:0] shaped_accel,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acss_pkg::IDX_W-1:0]         cfg_index,
    input  logic [acss_pkg::DATA_W-1:0]        cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WIN   = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SLEW  = 5'b01000,
        ST_CLAMP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [acss_pkg::CNT_W-1:0]         win_len_reg;
    logic signed [acss_pkg::DATA_W-1:0] out_min_reg;
    logic signed [acss_pkg::DATA_W-1:0] out_max_reg;
    logic [acss_pkg::DATA_W-1:0]        rise_step_reg;
    logic [acss_pkg::DATA_W-1:0]        fall_step_reg;

    logic signed [acss_pkg::DATA_W-1:0] prev_reg;
    logic signed [acss_pkg::DATA_W-1:0] mean_reg;
    logic signed [acss_pkg::SLEW_W-1:0] slew_reg, slew_next;
    logic signed [acss_pkg::DATA_W-1:0] clamp_val;
    logic                               out_valid_reg;
    logic signed [acss_pkg::DATA_W-1:0] out_data_reg;

    logic                       cfg_we;
    logic                       in_accept;
    logic                       out_load;
    logic [acss_pkg::CNT_W-1:0] act_len;

    logic signed [acss_pkg::SLEW_W-1:0] up_lim;
    logic signed [acss_pkg::SLEW_W-1:0] dn_lim;
    logic signed [acss_pkg::SLEW_W-1:0] mean_ext;

    acss_pkg::win_req_t win_req;
    acss_pkg::win_rsp_t win_rsp;
    acss_pkg::div_req_t div_req;
    acss_pkg::div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= acss_pkg::WINDOW_LEN_RST;
            out_min_reg   <= acss_pkg::OUT_MIN_RST;
            out_max_reg   <= acss_pkg::OUT_MAX_RST;
            rise_step_reg <= acss_pkg::RISE_STEP_RST;
            fall_step_reg <= acss_pkg::FALL_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acss_pkg::REG_WINDOW_LEN: win_len_reg   <= cfg_data[acss_pkg::CNT_W-1:0];
                acss_pkg::REG_OUT_MIN:    out_min_reg   <= $signed(cfg_data);
                acss_pkg::REG_OUT_MAX:    out_max_reg   <= $signed(cfg_data);
                acss_pkg::REG_RISE_STEP:  rise_step_reg <= cfg_data;
                acss_pkg::REG_FALL_STEP:  fall_step_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // effective window length
    always_comb
    begin
        act_len = win_len_reg;
        if (win_len_reg == '0)
        begin
            act_len = acss_pkg::CNT_W'(1);
        end
        else if (int'(win_len_reg) > WINDOW_DEPTH)
        begin
            act_len = acss_pkg::CNT_W'(WINDOW_DEPTH);
        end
    end

    // window memory and running sum
    assign win_req.start  = in_accept;
    assign win_req.clear  = cfg_we && (cfg_index == acss_pkg::REG_WINDOW_LEN);
    assign win_req.len    = act_len;
    assign win_req.sample = raw_accel;

    acss_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (win_req),
        .rsp  (win_rsp)
    );

    // mean of the held samples
    assign div_req.start    = (state_reg == ST_WIN) && win_rsp.done;
    assign div_req.dividend = win_rsp.sum;
    assign div_req.divisor  = win_rsp.count;

    acss_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // slew limits around the previous result
    assign mean_ext = acss_pkg::SLEW_W'(mean_reg);
    assign up_lim   = acss_pkg::SLEW_W'(prev_reg) + $signed({2'b00, rise_step_reg});
    assign dn_lim   = acss_pkg::SLEW_W'(prev_reg) - $signed({2'b00, fall_step_reg});

    always_comb
    begin
        if (mean_ext > up_lim)
        begin
            slew_next = up_lim;
        end
        else if (mean_ext < dn_lim)
        begin
            slew_next = dn_lim;
        end
        else
        begin
            slew_next = mean_ext;
        end
    end

    // clamp, upper bound first; the lower bound wins if the bounds cross
    always_comb
    begin
        clamp_val = acss_pkg::DATA_W'(slew_reg);
        if (slew_reg > acss_pkg::SLEW_W'(out_max_reg))
        begin
            clamp_val = out_max_reg;
        end
        if (slew_reg > acss_pkg::SLEW_W'(out_max_reg)
            ? (out_max_reg < out_min_reg)
            : (slew_reg < acss_pkg::SLEW_W'(out_min_reg)))
        begin
            clamp_val = out_min_reg;
        end
    end

    assign out_load = (state_reg == ST_CLAMP) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept)      state_next = ST_WIN;
            ST_WIN:   if (win_rsp.done)   state_next = ST_DIV;
            ST_DIV:   if (div_rsp.done)   state_next = ST_SLEW;
            ST_SLEW:                      state_next = ST_CLAMP;
            ST_CLAMP: if (out_load)       state_next = ST_IDLE;
            default:                      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                prev_reg      <= clamp_val;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            mean_reg <= div_rsp.mean;
        end
        if (state_reg == ST_SLEW)
        begin
            slew_reg <= slew_next;
        end
        if (out_load)
        begin
            out_data_reg <= clamp_val;
        end
    end

    assign out_valid    = out_valid_reg;
    assign shaped_accel = out_data_reg;

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("request taken but unit not busy");

    a_win_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        win_rsp.done |-> (state_reg == ST_WIN))
        else $error("window result outside window wait");

    a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divide result outside divide wait");

    a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        win_rsp.count <= act_len)
        else $error("held count above window length");

    a_out_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_CLAMP))
        else $error("result shown without clamp stage");

endmodule
